/* rtl/sha256_pkg.sv */
// shared types and constants for the sha-256 stream hasher
// payload structs, controller/datapath command and status, round constants
// no dependencies
package sha256_pkg;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [5:0] FILL_LEN_POS = 6'd56;
  localparam logic [5:0] ROUND_LAST   = 6'd63;
  localparam logic [2:0] IDX_LAST     = 3'd7;
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [63:0] LEN_STEP    = 64'd8;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } sha_bsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_COMP,
    S_ADD,
    S_OUT
  } sha_state_t;

  typedef struct packed {
    logic       push;
    sha_bsel_t  byte_sel;
    logic       add_len;
    logic [2:0] idx;
    logic       load_work;
    logic       do_round;
    logic [5:0] round_idx;
    logic       add_chain;
    logic       emit;
    logic       clear_msg;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_free;
  } sha_stat_t;

endpackage

/* rtl/sha256_ctrl.sv */
// controller for the sha-256 stream hasher: message, padding and round sequencing
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_stall,
  input  sha256_pkg::sha_stat_t status,
  output sha256_pkg::sha_cmd_t  cmd
);
  import sha256_pkg::*;

  sha_state_t state_r, state_nxt;
  logic [5:0] round_r, round_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       fin_r, fin_nxt;
  logic       last_r, last_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      last_r  <= last_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    cmd.round_idx = round_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.push = 1'b1;
          if (in_mode == MODE_FINISH) begin
            cmd.byte_sel = BSEL_PAD;
            fin_nxt      = 1'b1;
            state_nxt    = S_PAD_ZERO;
          end else begin
            cmd.byte_sel = BSEL_DATA;
            cmd.add_len  = 1'b1;
          end
          if (status.fill == FILL_LAST) begin
            cmd.load_work = 1'b1;
            round_nxt     = '0;
            state_nxt     = S_COMP;
          end
        end
      end
      S_PAD_ZERO: begin
        if (status.fill == FILL_LEN_POS) begin
          cnt_nxt   = '0;
          state_nxt = S_PAD_LEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
          if (status.fill == FILL_LAST) begin
            cmd.load_work = 1'b1;
            round_nxt     = '0;
            state_nxt     = S_COMP;
          end
        end
      end
      S_PAD_LEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        cnt_nxt      = cnt_r + 3'd1;
        if (status.fill == FILL_LAST) begin
          cmd.load_work = 1'b1;
          round_nxt     = '0;
          last_nxt      = 1'b1;
          state_nxt     = S_COMP;
        end
      end
      S_COMP: begin
        cmd.do_round = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        if (last_r) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else if (fin_r) begin
          state_nxt = S_PAD_ZERO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cnt_nxt  = cnt_r + 3'd1;
          if (cnt_r == IDX_LAST) begin
            cmd.clear_msg = 1'b1;
            fin_nxt       = 1'b0;
            last_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a block only starts compressing when its last byte goes in
  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_work |-> (cmd.push && status.fill == FILL_LAST))
    else $error("compression started on a partial block");

  // the round counter starts from zero on every block
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_work |=> (state_r == S_COMP && round_r == '0))
    else $error("round counter not cleared at block start");

  // chain add follows the final round
  a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && round_r == ROUND_LAST) |=> state_r == S_ADD)
    else $error("chain add did not follow the final round");

  // length bytes end exactly on a block boundary
  a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD_LEN && cnt_r == IDX_LAST) |-> status.fill == FILL_LAST)
    else $error("length field not aligned to block end");

endmodule

/* rtl/sha256_dp.sv */
// datapath for the sha-256 stream hasher: block shift line, round logic,
// chaining state, bit length and output register; depends on sha256_pkg
module sha256_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_byte,
  input  sha256_pkg::sha_cmd_t  cmd,
  output sha256_pkg::sha_stat_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::sha_out_t  out_data
);
  import sha256_pkg::*;

  // block bytes and schedule share one shift line; word 15 is the oldest
  logic [511:0]     blk_r, blk_nxt;
  logic [31:0]      work_r [8];
  logic [31:0]      work_nxt [8];
  logic [31:0]      h_r [8];
  logic [31:0]      h_nxt [8];
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      len_r, len_nxt;
  logic             out_valid_r, out_valid_nxt;
  sha_out_t         out_data_r, out_data_nxt;

  logic [7:0]  push_byte;
  logic [31:0] w_old, w_x, w_9, w_y, ws0, ws1, w_t;
  logic [31:0] ra, rb, rc, rd, re, rf, rg, rh;
  logic [31:0] bs0, bs1, ch, maj, t1, t2;

  // byte to push
  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_DATA: push_byte = in_byte;
      BSEL_PAD:  push_byte = PAD_BYTE;
      BSEL_ZERO: push_byte = '0;
      BSEL_LEN:  push_byte = len_r[8 * (7 - 32'(cmd.idx)) +: 8];
      default:   push_byte = '0;
    endcase
  end

  // message schedule word
  always_comb begin
    w_old = blk_r[32 * 15 +: 32];
    w_x   = blk_r[32 * 14 +: 32];
    w_9   = blk_r[32 * 6 +: 32];
    w_y   = blk_r[32 * 1 +: 32];
    ws0   = {w_x[6:0], w_x[31:7]} ^ {w_x[17:0], w_x[31:18]} ^ (w_x >> 3);
    ws1   = {w_y[16:0], w_y[31:17]} ^ {w_y[18:0], w_y[31:19]} ^ (w_y >> 10);
    if (cmd.round_idx[5:4] == 2'd0) begin
      w_t = w_old;
    end else begin
      w_t = w_old + ws0 + w_9 + ws1;
    end
  end

  // one compression round
  always_comb begin
    ra  = work_r[0];
    rb  = work_r[1];
    rc  = work_r[2];
    rd  = work_r[3];
    re  = work_r[4];
    rf  = work_r[5];
    rg  = work_r[6];
    rh  = work_r[7];
    bs1 = {re[5:0], re[31:6]} ^ {re[10:0], re[31:11]} ^ {re[24:0], re[31:25]};
    ch  = (re & rf) ^ (~re & rg);
    t1  = rh + bs1 + ch + ROUND_K[cmd.round_idx] + w_t;
    bs0 = {ra[1:0], ra[31:2]} ^ {ra[12:0], ra[31:13]} ^ {ra[21:0], ra[31:22]};
    maj = (ra & rb) ^ (ra & rc) ^ (rb & rc);
    t2  = bs0 + maj;
  end

  // next values
  always_comb begin
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    work_nxt      = work_r;
    h_nxt         = h_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.push) begin
      blk_nxt  = {blk_r[503:0], push_byte};
      fill_nxt = fill_r + 6'd1;
    end
    if (cmd.add_len) begin
      len_nxt = len_r + LEN_STEP;
    end
    if (cmd.load_work) begin
      work_nxt = h_r;
    end
    if (cmd.do_round) begin
      blk_nxt     = {blk_r[479:0], w_t};
      work_nxt[0] = t1 + t2;
      work_nxt[1] = ra;
      work_nxt[2] = rb;
      work_nxt[3] = rc;
      work_nxt[4] = rd + t1;
      work_nxt[5] = re;
      work_nxt[6] = rf;
      work_nxt[7] = rg;
    end
    if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        h_nxt[i] = h_r[i] + work_r[i];
      end
    end
    if (cmd.emit) begin
      out_data_nxt.digest_word = h_r[cmd.idx];
      out_data_nxt.word_index  = cmd.idx;
      out_data_nxt.last_word   = (cmd.idx == IDX_LAST);
      out_valid_nxt            = 1'b1;
    end
    if (cmd.clear_msg) begin
      h_nxt    = H_INIT;
      fill_nxt = '0;
      len_nxt  = '0;
    end
  end

  // control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= H_INIT;
      fill_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      h_r         <= h_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    work_r     <= work_nxt;
    out_data_r <= out_data_nxt;
  end

  assign status.fill     = fill_r;
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // a new word never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("digest word overwritten while stalled");

  // message state is back to empty after the digest goes out
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_msg |=> (fill_r == '0 && len_r == '0 && h_r[0] == H_INIT[0]))
    else $error("message state not cleared after finish");

endmodule

/* rtl/sha256_stream_hasher_unit.sv */
// sha-256 stream hasher: one message byte per word, eight digest words out.
// absorb: an accepted word pushes its byte; a full block then runs all rounds and the chain add.
// finish: padding and length bytes, one or two block compressions, then 8 output words.
// rounds run one per cycle on a single round unit; input waits while it is busy.
// synchronous active-low reset loads the initial hash values and empties the message.
module sha256_stream_hasher_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha256_pkg::sha_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha256_pkg::sha_out_t out_data
);
  import sha256_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t status;

  // sequencing
  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // hashing datapath
  sha256_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_data.data_byte),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* bench/sha256_stream_hasher_unit_tb.sv */
// self-checking bench for sha256_stream_hasher_unit: byte messages in, digest words out
// keeps its own sha-256 tracker and checks every digest word in order
// depends on sha256_pkg for the payload types and mode codes
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;
  import sha256_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam int TARGET_WORDS = 300;
  localparam int MIN_DIGESTS  = 8;
  localparam int PHASE_WORDS  = 37;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam int         LEN_OFFSET = 56;

  // idle/stall patterns, stepped through as words are accepted
  localparam int PH_NONE   = 0;
  localparam int PH_SENDER = 1;
  localparam int PH_RECV   = 2;
  localparam int PH_BOTH   = 3;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sha_out_t out_data;

  sha256_stream_hasher_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // tracker state: chaining words, block buffer, fill level, bit length
  logic [31:0] chain_h [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] msg_bits;

  sha_in_t  msg_words [$];
  sha_out_t digest_due [$];

  int  words_in;
  int  mismatches;
  int  idle_count;
  logic in_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one 64-round compression of msg_block into chain_h
  task automatic compress_block;
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
      t1 = r[7] + s1 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + SHA_K[t] + w[t];
      s0 = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
      t2 = s0 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + r[i];
  endtask

  task automatic load_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  task automatic clear_hash;
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_H0[i];
    block_fill = 0;
    msg_bits   = '0;
  endtask

  // absorb a byte, or pad, compress and queue the eight digest words
  task automatic track_word(input sha_in_t w);
    logic [63:0] len;
    sha_out_t    d;
    if (w.mode == MODE_ABSORB) begin
      load_byte(w.data_byte);
      msg_bits = msg_bits + 64'd8;
    end else begin
      len = msg_bits;
      load_byte(PAD_MARK);
      while (block_fill != LEN_OFFSET) load_byte(8'h00);
      for (int i = 0; i < 8; i++) load_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = chain_h[i];
        d.word_index  = 3'(i);
        d.last_word   = (i == 7);
        digest_due.push_back(d);
      end
      clear_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic put_word(input logic mode, input logic [7:0] b);
    sha_in_t w;
    w.mode      = mode;
    w.data_byte = b;
    msg_words.push_back(w);
  endtask

  // random bytes followed by a finish with a random (ignored) data byte
  task automatic put_message(input int nbytes);
    for (int i = 0; i < nbytes; i++) put_word(MODE_ABSORB, 8'($urandom));
    put_word(MODE_FINISH, 8'($urandom));
  endtask

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin
    int ph;
    ph = (words_in / PHASE_WORDS) % 4;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (msg_words.size() != 0 &&
          !(ph == PH_SENDER && $urandom_range(99) < 74) &&
          !(ph == PH_BOTH && $urandom_range(99) < 30)) begin
        in_valid <= 1'b1;
        in_data  <= msg_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (ph == PH_RECV)
      out_stall <= ($urandom_range(99) < 74);
    else if (ph == PH_BOTH)
      out_stall <= ($urandom_range(99) < 30);
    else
      out_stall <= 1'b0;
  end

  // monitor: track accepted words and check digest words
  always @(posedge clk) begin
    sha_out_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      track_word(in_data);
      words_in++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (digest_due.size() == 0) begin
        report_mismatch("unexpected digest word", out_data.digest_word, '0);
      end else begin
        want = digest_due.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    int nbytes;
    int digests;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    in_taken   = 1'b0;
    words_in   = 0;
    mismatches = 0;
    idle_count = 0;
    digests    = 0;
    clear_hash();

    // directed: empty message twice, "abc", single zero and all-ones bytes, then the two bytes 55 aa
    put_word(MODE_FINISH, 8'h00);
    put_word(MODE_FINISH, 8'hff);
    put_word(MODE_ABSORB, 8'h61);
    put_word(MODE_ABSORB, 8'h62);
    put_word(MODE_ABSORB, 8'h63);
    put_word(MODE_FINISH, 8'h00);
    put_word(MODE_ABSORB, 8'h00);
    put_word(MODE_FINISH, 8'hff);
    put_word(MODE_ABSORB, 8'hff);
    put_word(MODE_FINISH, 8'h00);
    put_word(MODE_ABSORB, 8'h55);
    put_word(MODE_ABSORB, 8'haa);
    put_word(MODE_FINISH, 8'h80);

    // random messages, some sized around the padding and block boundaries
    while (msg_words.size() < TARGET_WORDS || digests < MIN_DIGESTS) begin
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(7))
          0: nbytes = 55;
          1: nbytes = 56;
          2: nbytes = 57;
          3: nbytes = 63;
          4: nbytes = 64;
          5: nbytes = 65;
          6: nbytes = 119;
          default: nbytes = 120;
        endcase
      end else begin
        nbytes = $urandom_range(30);
      end
      put_message(nbytes);
      digests++;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // drain: all words sent, all digests back, then a quiet tail
    while (msg_words.size() != 0 || in_valid) @(posedge clk);
    while (digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_dp.sv
rtl/sha256_stream_hasher_unit.sv
bench/sha256_stream_hasher_unit_tb.sv
